// ===== design/bnfa_pkg.sv =====
// shared types and constants for the bitmap next-fit block allocator
// item structs, opcodes and the controller/datapath command and status structs
`timescale 1ns / 1ps

package bnfa_pkg;

  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int BLK_W          = 10;
  localparam int SEARCH_W       = 10;

  typedef enum logic [1:0] {
    OP_ALLOC     = 2'd0,
    OP_LOAD_BYTE = 2'd1,
    OP_SET_PTR   = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [6:0]          byte_index;
    logic [7:0]          byte_value;
    logic [SEARCH_W-1:0] search_start;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0] block_index;
    logic             found;
  } out_item_t;

  typedef struct packed {
    logic clear_step;
    logic load_byte;
    logic ptr_load;
    logic ptr_step;
    logic scan_start;
    logic scan_check;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic ptr_ge;
    logic hit;
    logic scan_last;
  } dp_sts_t;

endpackage

// ===== design/bitmap_next_fit_block_allocator_core.sv =====
// top level of the bitmap next-fit block allocator
// instantiates bnfa_ctrl and bnfa_dp, depends on bnfa_pkg
`timescale 1ns / 1ps

// Next-fit block allocator over a free-block bitmap held in an on-chip byte memory of
// ceil(NUM_BLOCKS/8) entries. After reset the block runs a clearing pass with in_stall
// high. An allocate item scans the bitmap byte by byte (memory read, then check and
// update), from the search pointer with wraparound, never handing out block 0; its last
// step loads the result into the output register, and a full map returns found clear.
// That load waits while an earlier result is still stalled in the output register. A
// load byte item writes its byte if the index is in range and gives no result. A set
// pointer item reduces the value modulo NUM_BLOCKS by repeated subtraction, with no
// result. One item is in work at a time; a finished result waits in the output
// register while the next item is taken.
module bitmap_next_fit_block_allocator_core import bnfa_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bnfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  bnfa_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.block_index == '0)
    else $error("no-block result carries a nonzero index");

  a_found_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.block_index != '0)
    else $error("block 0 handed out");

  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.opcode == OP_ALLOC) |=> in_stall)
    else $error("input taken while an allocation is in work");

endmodule

// ===== design/bnfa_dp.sv =====
// datapath of the allocator: bitmap memory, search pointer, byte scanner, result register
// depends on bnfa_pkg
`timescale 1ns / 1ps

module bnfa_dp import bnfa_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  in_item_t  in_data,
  output dp_sts_t   sts,
  output out_item_t out_data
);

  localparam int BYTES = (NUM_BLOCKS + 7) / 8;
  localparam int AW    = $clog2(BYTES);
  localparam int PTR_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(BYTES + 1);
  localparam int RED_W = (PTR_W > SEARCH_W) ? PTR_W : SEARCH_W;
  localparam logic [31:0]   NB        = 32'(NUM_BLOCKS);
  localparam logic [AW-1:0] LAST_BYTE = AW'(BYTES - 1);

  logic [7:0]       mem [BYTES];
  logic [7:0]       rdata_r;
  logic [AW-1:0]    byte_r;
  logic [2:0]       off_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] ptr_r;
  logic [RED_W-1:0] red_r;
  out_item_t        res_r;
  out_item_t        out_r;

  logic [7:0]    allow;
  logic [7:0]    free_bits;
  logic [7:0]    hit_onehot;
  logic [2:0]    hit_pos;
  logic          hit;
  logic          first_pass;
  logic          last_pass;
  logic          clear_last;
  logic          ptr_ge;
  logic          load_ok;
  logic          ptr_wrap;
  logic [AW+2:0] hit_blk;
  logic [AW+3:0] hit_inc;

  assign first_pass = (cnt_r == '0);
  assign last_pass  = (cnt_r == CNT_W'(BYTES));
  assign clear_last = (byte_r == LAST_BYTE);
  assign ptr_ge     = (32'(red_r) >= NB);
  assign load_ok    = (32'(in_data.byte_index) < 32'(BYTES));

  // blocks eligible in the current byte: in range, not block 0, inside the round
  always_comb begin
    allow = '0;
    for (int j = 0; j < 8; j++) begin
      allow[j] = (32'({byte_r, 3'(j)}) < NB) && ({byte_r, 3'(j)} != '0) &&
                 (!first_pass || (3'(j) >= off_r)) && (!last_pass || (3'(j) < off_r));
    end
    free_bits = ~rdata_r & allow;
    hit_pos = '0;
    for (int j = 7; j >= 0; j--) begin
      if (free_bits[j]) begin
        hit_pos = 3'(j);
      end
    end
  end

  assign hit        = |free_bits;
  assign hit_onehot = 8'(1) << hit_pos;
  assign hit_blk    = {byte_r, hit_pos};
  assign hit_inc    = {1'b0, hit_blk} + 1'b1;
  assign ptr_wrap   = (32'(hit_inc) == NB);

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[byte_r] <= '0;
    end else if (cmd.load_byte && load_ok) begin
      mem[AW'(in_data.byte_index)] <= in_data.byte_value;
    end else if (cmd.scan_check && hit) begin
      mem[byte_r] <= rdata_r | hit_onehot;
    end
    rdata_r <= mem[byte_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
      ptr_r  <= PTR_W'(1 % NUM_BLOCKS);
    end else begin
      if (cmd.clear_step) begin
        byte_r <= clear_last ? '0 : byte_r + 1'b1;
      end else if (cmd.scan_start) begin
        byte_r <= AW'(ptr_r >> 3);
      end else if (cmd.scan_check && !hit) begin
        byte_r <= clear_last ? '0 : byte_r + 1'b1;
      end
      if (cmd.ptr_step && !ptr_ge) begin
        ptr_r <= PTR_W'(red_r);
      end else if (cmd.scan_check && hit) begin
        ptr_r <= ptr_wrap ? '0 : PTR_W'(hit_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      off_r <= ptr_r[2:0];
      cnt_r <= '0;
    end else if (cmd.scan_check) begin
      cnt_r <= cnt_r + 1'b1;
    end
    // pointer reduction modulo the block count
    if (cmd.ptr_load) begin
      red_r <= RED_W'(in_data.search_start);
    end else if (cmd.ptr_step && ptr_ge) begin
      red_r <= red_r - RED_W'(NUM_BLOCKS);
    end
    if (cmd.scan_check) begin
      res_r.block_index <= hit ? BLK_W'(hit_blk) : '0;
      res_r.found       <= hit;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign sts.clear_last = clear_last;
  assign sts.ptr_ge     = ptr_ge;
  assign sts.hit        = hit;
  assign sts.scan_last  = last_pass;
  assign out_data       = out_r;

endmodule

// ===== design/bnfa_ctrl.sv =====
// controller of the allocator: clearing pass, opcode decode, scan sequencing, output valid
// depends on bnfa_pkg
`timescale 1ns / 1ps

module bnfa_ctrl import bnfa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SETP  = 6'b000100,
    S_READ  = 6'b001000,
    S_CHECK = 6'b010000,
    S_PUSH  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_opcode)
            OP_ALLOC: begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_READ;
            end
            OP_LOAD_BYTE: begin
              cmd.load_byte = 1'b1;
            end
            OP_SET_PTR: begin
              cmd.ptr_load = 1'b1;
              state_nxt    = S_SETP;
            end
            default: begin
            end
          endcase
        end
      end
      S_SETP: begin
        cmd.ptr_step = 1'b1;
        if (!sts.ptr_ge) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.scan_check = 1'b1;
        state_nxt      = (sts.hit || sts.scan_last) ? S_PUSH : S_READ;
      end
      S_PUSH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== tb/tb_bitmap_next_fit_block_allocator_core.sv =====
// testbench for the bitmap next-fit block allocator: directed table, then random item sequences
// checks results against the table or a bitmap/pointer predictor; needs bnfa_pkg and the core
`timescale 1ns / 1ps

module tb_bitmap_next_fit_block_allocator_core import bnfa_pkg::*; ();

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAP_BYTES = (NUM_BLOCKS_DEF + 7) / 8;
  localparam int ITEM_TARGET = 1150;
  localparam int DRAIN_CYCLES = 2 * (MAP_BYTES + 1) + 40;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } step_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic [7:0] usage_map [MAP_BYTES];
  logic [9:0] search_ptr;
  out_item_t  alloc_q [$];
  bit         quiet = 1'b0;
  int         fails = 0;
  int         sent = 0;

  step_t dir_steps [22] = '{
    '{'{OP_ALLOC,     7'd0,   8'h00, 10'd0},    1'b1, '{10'd1,    1'b1}},
    '{'{OP_ALLOC,     7'd0,   8'h00, 10'd0},    1'b1, '{10'd2,    1'b1}},
    '{'{OP_UNUSED,    7'h7f,  8'hff, 10'h3ff},  1'b0, '{10'd0,    1'b0}},
    '{'{OP_SET_PTR,   7'd0,   8'h00, 10'd1023}, 1'b0, '{10'd0,    1'b0}},
    '{'{OP_ALLOC,     7'd0,   8'h00, 10'd0},    1'b1, '{10'd1023, 1'b1}},
    '{'{OP_ALLOC,     7'd0,   8'h00, 10'd0},    1'b1, '{10'd3,    1'b1}},
    '{'{OP_SET_PTR,   7'd0,   8'h00, 10'd0},    1'b0, '{10'd0,    1'b0}},
    '{'{OP_ALLOC,     7'd0,   8'h00, 10'd0},    1'b1, '{10'd4,    1'b1}},
    '{'{OP_LOAD_BYTE, 7'd127, 8'hff, 10'd0},    1'b0, '{10'd0,    1'b0}},
    '{'{OP_SET_PTR,   7'd0,   8'h00, 10'd1016}, 1'b0, '{10'd0,    1'b0}},
    '{'{OP_ALLOC,     7'd0,   8'h00, 10'd0},    1'b1, '{10'd5,    1'b1}},
    '{'{OP_LOAD_BYTE, 7'd0,   8'h00, 10'd0},    1'b0, '{10'd0,    1'b0}},
    '{'{OP_SET_PTR,   7'd0,   8'h00, 10'd0},    1'b0, '{10'd0,    1'b0}},
    '{'{OP_ALLOC,     7'd0,   8'h00, 10'd0},    1'b1, '{10'd1,    1'b1}},
    '{'{OP_LOAD_BYTE, 7'd1,   8'hff, 10'd0},    1'b0, '{10'd0,    1'b0}},
    '{'{OP_LOAD_BYTE, 7'd0,   8'hfe, 10'd0},    1'b0, '{10'd0,    1'b0}},
    '{'{OP_SET_PTR,   7'd0,   8'h00, 10'h155},  1'b0, '{10'd0,    1'b0}},
    '{'{OP_ALLOC,     7'd0,   8'h00, 10'd0},    1'b1, '{10'd341,  1'b1}},
    '{'{OP_LOAD_BYTE, 7'd42,  8'haa, 10'd0},    1'b0, '{10'd0,    1'b0}},
    '{'{OP_ALLOC,     7'h55,  8'h55, 10'h2aa},  1'b0, '{10'd0,    1'b0}},
    '{'{OP_SET_PTR,   7'd0,   8'h00, 10'h2aa},  1'b0, '{10'd0,    1'b0}},
    '{'{OP_ALLOC,     7'd0,   8'h00, 10'd0},    1'b0, '{10'd0,    1'b0}}
  };

  bitmap_next_fit_block_allocator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // updates map/pointer; next-fit scan, block 0 never handed out, one full round at most
  function automatic bit predict_alloc(in_item_t it, output out_item_t res);
    logic [9:0] cand;
    res = '0;
    case (it.opcode)
      OP_LOAD_BYTE: begin
        usage_map[it.byte_index] = it.byte_value;
        return 1'b0;
      end
      OP_SET_PTR: begin
        search_ptr = it.search_start;
        return 1'b0;
      end
      OP_ALLOC: begin
        cand = (search_ptr == 10'd0) ? 10'd1 : search_ptr;
        for (int n = 0; n < NUM_BLOCKS_DEF - 1; n++) begin
          if (!usage_map[cand[9:3]][cand[2:0]]) begin
            usage_map[cand[9:3]][cand[2:0]] = 1'b1;
            search_ptr = cand + 10'd1;
            res.block_index = cand;
            res.found = 1'b1;
            return 1'b1;
          end
          cand = cand + 10'd1;
          if (cand == 10'd0) cand = 10'd1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic in_item_t rand_item(logic [1:0] op);
    in_item_t it;
    it.opcode       = op;
    it.byte_index   = 7'($urandom);
    it.byte_value   = 8'($urandom);
    it.search_start = 10'($urandom);
    return it;
  endfunction

  task automatic send_item(in_item_t it, logic typed = 1'b0, out_item_t want = '0);
    out_item_t res;
    int g;
    if (!in_valid) in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (predict_alloc(it, res)) alloc_q.push_back(typed ? want : res);
    if (it.opcode != OP_UNUSED) sent++;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // load a nearly or fully used map, then allocate into whatever is left
  task automatic fill_map();
    int mode;
    in_item_t it;
    mode = $urandom_range(0, 1);
    for (int t = 0; t < MAP_BYTES; t++) begin
      it = rand_item(OP_LOAD_BYTE);
      it.byte_index = 7'(t);
      it.byte_value = 8'hff;
      if (mode == 1 && $urandom_range(0, 15) == 0) begin
        it.byte_value = 8'hff ^ (8'h01 << $urandom_range(0, 7));
      end
      if (t == 0 && $urandom_range(0, 1)) it.byte_value = 8'hfe;
      send_item(it);
    end
    send_item(rand_item(OP_SET_PTR));
    repeat ($urandom_range(2, 6)) send_item(rand_item(OP_ALLOC));
  endtask

  task automatic mixed_ops();
    int r;
    repeat ($urandom_range(6, 20)) begin
      r = $urandom_range(0, 9);
      if (r < 5) send_item(rand_item(OP_ALLOC));
      else if (r < 7) send_item(rand_item(OP_LOAD_BYTE));
      else if (r < 9) send_item(rand_item(OP_SET_PTR));
      else send_item(rand_item(OP_UNUSED));
    end
  endtask

  initial begin : stall_gen
    int n;
    forever begin
      @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(0, 7)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (alloc_q.size() == 0) begin
        $error("unexpected result block_index=%0d found=%0b",
               out_data.block_index, out_data.found);
        fails++;
      end else begin
        want = alloc_q.pop_front();
        if (out_data.block_index !== want.block_index) begin
          $error("block_index expected %0d actual %0d", want.block_index,
                 out_data.block_index);
          fails++;
        end
        if (out_data.found !== want.found) begin
          $error("found expected %0b actual %0b", want.found, out_data.found);
          fails++;
        end
      end
    end
  end

  initial begin : stimulus
    int kind;
    foreach (usage_map[i]) usage_map[i] = 8'h00;
    search_ptr = 10'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_steps[i]) send_item(dir_steps[i].item, dir_steps[i].typed, dir_steps[i].want);

    while (sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 2) fill_map();
      else mixed_ops();
    end
    if (in_valid) in_valid <= 1'b0;

    while (alloc_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (alloc_q.size() != 0) begin
      $error("%0d results never arrived", alloc_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("[bitmap_next_fit_block_allocator_core] OK");
    end else begin
      $display("[bitmap_next_fit_block_allocator_core] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("[bitmap_next_fit_block_allocator_core] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/bnfa_pkg.sv
design/bnfa_dp.sv
design/bnfa_ctrl.sv
design/bitmap_next_fit_block_allocator_core.sv
tb/tb_bitmap_next_fit_block_allocator_core.sv
